FILE: src/mrp_pkg.sv
// Shared types, constants and key tables of the match rule parser.
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int POS_W    = 15;
    localparam int VLEN_W   = 9;
    localparam int LEN_W    = 8;
    localparam int KLEN_W   = 4;
    localparam int NUM_KEYS = 8;
    localparam int NUM_RECS = 4;
    localparam int KEY_CHARS = 16;
    localparam int SIG_CHARS = 8;

    localparam logic [POS_W-1:0]  MAX_RULE_LEN  = 15'h7FFF;
    localparam logic [VLEN_W-1:0] MAX_VALUE_LEN = 9'd255;
    localparam logic [VLEN_W-1:0] SIGNAL_LEN    = 9'd6;
    localparam logic [KLEN_W-1:0] KEY_LEN_SAT   = 4'd15;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_OPENQ,
        PH_VALUE,
        PH_AFTER
    } phase_t;

    typedef enum logic [2:0] {
        KEY_TYPE,
        KEY_PATH,
        KEY_SENDER,
        KEY_MEMBER,
        KEY_IFACE,
        KEY_EAVES,
        KEY_DEST,
        KEY_PATHNS
    } key_t;

    typedef enum logic [1:0] {
        REC_PATH,
        REC_SENDER,
        REC_MEMBER,
        REC_IFACE
    } rec_t;

    localparam logic [8*KEY_CHARS-1:0] KEY_STR [NUM_KEYS] = '{
        "type", "path", "sender", "member", "interface",
        "eavesdrop", "destination", {"path_", "namespace"}
    };

    localparam logic [KLEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
        4'd4, 4'd4, 4'd6, 4'd6, 4'd9, 4'd9, 4'd11, 4'd14
    };

    localparam logic [8*SIG_CHARS-1:0] SIGNAL_STR = {"signal", 16'h0000};

    typedef struct packed {
        logic [7:0] rule_byte;
        logic       last_byte;
    } rule_item_t;

    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] path_offset;
        logic [LEN_W-1:0] path_length;
        logic             path_children;
        logic [POS_W-1:0] sender_offset;
        logic [LEN_W-1:0] sender_length;
        logic [POS_W-1:0] member_offset;
        logic [LEN_W-1:0] member_length;
        logic [POS_W-1:0] interface_offset;
        logic [LEN_W-1:0] interface_length;
    } result_item_t;

    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } record_t;

    // Keys whose character at idx equals b.
    function automatic logic [NUM_KEYS-1:0] key_hits(input logic [KLEN_W-1:0] idx,
                                                    input logic [7:0] b);
        logic [8*KEY_CHARS-1:0] s;
        logic [NUM_KEYS-1:0]    h;
        h = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            s = KEY_STR[k] << (8 * (KEY_CHARS - int'(KEY_LEN[k])));
            h[k] = (idx < KEY_LEN[k]) && (s[8*(KEY_CHARS-1-int'(idx)) +: 8] == b);
        end
        return h;
    endfunction

    // Keys of exactly length len.
    function automatic logic [NUM_KEYS-1:0] key_len_hits(input logic [KLEN_W-1:0] len);
        logic [NUM_KEYS-1:0] h;
        h = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            h[k] = (KEY_LEN[k] == len);
        end
        return h;
    endfunction

    function automatic logic signal_char_ok(input logic [VLEN_W-1:0] idx,
                                            input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (idx < SIGNAL_LEN)
        begin
            ok = (SIGNAL_STR[8*(SIG_CHARS-1-int'(idx[2:0])) +: 8] == b);
        end
        return ok;
    endfunction

endpackage

FILE: src/mrp_if.sv
// Stream interfaces for rule bytes and parse results.
`timescale 1ns / 1ps

interface mrp_rule_if;
    logic                valid;
    logic                ready;
    mrp_pkg::rule_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mrp_result_if;
    logic                  valid;
    logic                  ready;
    mrp_pkg::result_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: src/mrp_in_stage.sv
// Input register slice for rule byte transactions.
`timescale 1ns / 1ps

module mrp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    mrp_rule_if.sink            rule_stream,
    input  logic                take,
    output logic                item_valid,
    output mrp_pkg::rule_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    mrp_pkg::rule_item_t item_reg;
    mrp_pkg::rule_item_t item_next;
    logic                open;

    assign open              = !valid_reg || take;
    assign rule_stream.ready = open;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (open)
        begin
            valid_next = rule_stream.valid;
            if (rule_stream.valid)
            begin
                item_next = rule_stream.item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/mrp_parse_core.sv
// Parse state of one rule and the per-byte next-state logic.
`timescale 1ns / 1ps

module mrp_parse_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  consume,
    input  mrp_pkg::rule_item_t   item,
    output logic                  res_load,
    output mrp_pkg::result_item_t res_item
);

    mrp_pkg::phase_t                  phase_reg, phase_next;
    logic [mrp_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [mrp_pkg::KLEN_W-1:0]       klen_reg, klen_next;
    logic [mrp_pkg::NUM_KEYS-1:0]     cand_reg, cand_next;
    logic [mrp_pkg::POS_W-1:0]        vstart_reg, vstart_next;
    logic [mrp_pkg::VLEN_W-1:0]       vlen_reg, vlen_next;
    logic                             sig_reg, sig_next;
    logic                             err_reg, err_next;
    logic                             children_reg, children_next;
    logic                             slash_reg, slash_next;
    mrp_pkg::record_t                 recs_reg [mrp_pkg::NUM_RECS];
    mrp_pkg::record_t                 recs_next [mrp_pkg::NUM_RECS];

    mrp_pkg::key_t                    which;
    logic                             found;
    logic                             do_store;
    logic                             set_children;
    mrp_pkg::rec_t                    rec_sel;
    logic [mrp_pkg::LEN_W-1:0]        rec_len;
    logic [7:0]                       b;

    assign b = item.rule_byte;

    always_comb
    begin
        which = mrp_pkg::KEY_TYPE;
        found = 1'b0;
        for (int k = 0; k < mrp_pkg::NUM_KEYS; k++)
        begin
            if (cand_reg[k])
            begin
                which = mrp_pkg::key_t'(3'(k));
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        do_store     = 1'b0;
        set_children = 1'b0;
        rec_sel      = mrp_pkg::REC_PATH;
        rec_len      = vlen_reg[mrp_pkg::LEN_W-1:0];
        case (which)
            mrp_pkg::KEY_PATH:
            begin
                do_store = 1'b1;
            end
            mrp_pkg::KEY_SENDER:
            begin
                do_store = 1'b1;
                rec_sel  = mrp_pkg::REC_SENDER;
            end
            mrp_pkg::KEY_MEMBER:
            begin
                do_store = 1'b1;
                rec_sel  = mrp_pkg::REC_MEMBER;
            end
            mrp_pkg::KEY_IFACE:
            begin
                do_store = 1'b1;
                rec_sel  = mrp_pkg::REC_IFACE;
            end
            mrp_pkg::KEY_PATHNS:
            begin
                do_store     = 1'b1;
                set_children = 1'b1;
                if ((vlen_reg != '0) && slash_reg)
                begin
                    rec_len = vlen_reg[mrp_pkg::LEN_W-1:0] - 1'b1;
                end
            end
            default:
            begin
                do_store = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        klen_next     = klen_reg;
        cand_next     = cand_reg;
        vstart_next   = vstart_reg;
        vlen_next     = vlen_reg;
        sig_next      = sig_reg;
        err_next      = err_reg;
        children_next = children_reg;
        slash_next    = slash_reg;
        recs_next     = recs_reg;
        res_load      = 1'b0;
        res_item      = '0;

        if (consume)
        begin
            if (pos_reg == mrp_pkg::MAX_RULE_LEN)
            begin
                err_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end

            if (!err_next)
            begin
                case (phase_reg)
                    mrp_pkg::PH_KEY:
                    begin
                        if (b == mrp_pkg::CH_BACKSLASH || b == mrp_pkg::CH_SPACE ||
                            b == mrp_pkg::CH_NUL)
                        begin
                            err_next = 1'b1;
                        end
                        else if (b == mrp_pkg::CH_EQUALS)
                        begin
                            cand_next  = cand_reg & mrp_pkg::key_len_hits(klen_reg);
                            phase_next = mrp_pkg::PH_OPENQ;
                        end
                        else
                        begin
                            cand_next = cand_reg & mrp_pkg::key_hits(klen_reg, b);
                            if (klen_reg != mrp_pkg::KEY_LEN_SAT)
                            begin
                                klen_next = klen_reg + 1'b1;
                            end
                        end
                    end
                    mrp_pkg::PH_OPENQ:
                    begin
                        if (b != mrp_pkg::CH_QUOTE)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            vstart_next = pos_reg;
                            vlen_next   = '0;
                            sig_next    = 1'b1;
                            slash_next  = 1'b0;
                            phase_next  = mrp_pkg::PH_VALUE;
                        end
                    end
                    mrp_pkg::PH_VALUE:
                    begin
                        if (b == mrp_pkg::CH_BACKSLASH || b == mrp_pkg::CH_NUL)
                        begin
                            err_next = 1'b1;
                        end
                        else if (b == mrp_pkg::CH_QUOTE)
                        begin
                            phase_next = mrp_pkg::PH_AFTER;
                            if (vlen_reg > mrp_pkg::MAX_VALUE_LEN)
                            begin
                                err_next = 1'b1;
                            end
                            else if (found)
                            begin
                                if (which == mrp_pkg::KEY_TYPE)
                                begin
                                    if (!(sig_reg && vlen_reg == mrp_pkg::SIGNAL_LEN))
                                    begin
                                        err_next = 1'b1;
                                    end
                                end
                                else if (which == mrp_pkg::KEY_EAVES ||
                                         which == mrp_pkg::KEY_DEST)
                                begin
                                    err_next = 1'b1;
                                end
                                else if (do_store)
                                begin
                                    if (recs_reg[rec_sel].offset != '0)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        recs_next[rec_sel] = '{offset: vstart_reg,
                                                               length: rec_len};
                                        if (set_children)
                                        begin
                                            children_next = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        else
                        begin
                            if (!mrp_pkg::signal_char_ok(vlen_reg, b))
                            begin
                                sig_next = 1'b0;
                            end
                            slash_next = (b == mrp_pkg::CH_SLASH);
                            if (vlen_reg <= mrp_pkg::MAX_VALUE_LEN)
                            begin
                                vlen_next = vlen_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (b != mrp_pkg::CH_COMMA)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            klen_next  = '0;
                            cand_next  = '1;
                            phase_next = mrp_pkg::PH_KEY;
                        end
                    end
                endcase
            end

            if (item.last_byte)
            begin
                res_load        = 1'b1;
                res_item.status = err_next ||
                    !((phase_next == mrp_pkg::PH_AFTER) ||
                      (phase_next == mrp_pkg::PH_KEY && klen_next == '0));
                if (!res_item.status)
                begin
                    res_item.path_offset      = recs_next[mrp_pkg::REC_PATH].offset;
                    res_item.path_length      = recs_next[mrp_pkg::REC_PATH].length;
                    res_item.path_children    = children_next;
                    res_item.sender_offset    = recs_next[mrp_pkg::REC_SENDER].offset;
                    res_item.sender_length    = recs_next[mrp_pkg::REC_SENDER].length;
                    res_item.member_offset    = recs_next[mrp_pkg::REC_MEMBER].offset;
                    res_item.member_length    = recs_next[mrp_pkg::REC_MEMBER].length;
                    res_item.interface_offset = recs_next[mrp_pkg::REC_IFACE].offset;
                    res_item.interface_length = recs_next[mrp_pkg::REC_IFACE].length;
                end

                // rearm for the next rule
                phase_next    = mrp_pkg::PH_KEY;
                pos_next      = '0;
                klen_next     = '0;
                cand_next     = '1;
                vstart_next   = '0;
                vlen_next     = '0;
                sig_next      = 1'b1;
                err_next      = 1'b0;
                children_next = 1'b0;
                slash_next    = 1'b0;
                for (int r = 0; r < mrp_pkg::NUM_RECS; r++)
                begin
                    recs_next[r] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mrp_pkg::PH_KEY;
            pos_reg      <= '0;
            klen_reg     <= '0;
            cand_reg     <= '1;
            vstart_reg   <= '0;
            vlen_reg     <= '0;
            sig_reg      <= 1'b1;
            err_reg      <= 1'b0;
            children_reg <= 1'b0;
            slash_reg    <= 1'b0;
            for (int r = 0; r < mrp_pkg::NUM_RECS; r++)
            begin
                recs_reg[r] <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            klen_reg     <= klen_next;
            cand_reg     <= cand_next;
            vstart_reg   <= vstart_next;
            vlen_reg     <= vlen_next;
            sig_reg      <= sig_next;
            err_reg      <= err_next;
            children_reg <= children_next;
            slash_reg    <= slash_next;
            recs_reg     <= recs_next;
        end
    end

endmodule

FILE: src/mrp_out_stage.sv
// Result register driving the result transaction channel.
`timescale 1ns / 1ps

module mrp_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  mrp_pkg::result_item_t item,
    output logic                  free,
    mrp_result_if.source          result_stream
);

    logic                  valid_reg;
    logic                  valid_next;
    mrp_pkg::result_item_t item_reg;
    mrp_pkg::result_item_t item_next;

    assign free = !valid_reg || result_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (free)
        begin
            valid_next = load;
        end
        if (load)
        begin
            item_next = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign result_stream.valid = valid_reg;
    assign result_stream.item  = item_reg;

endmodule

FILE: src/match_rule_parser_unit.sv
// Top level of the match rule parser.
//
//   channel        role    payload                             transaction
//   rule_stream    sink    rule_byte, last_byte                one rule text byte
//   result_stream  source  status, path/sender/member/         one parse result per rule
//                          interface offset and length
//
// Takes one byte per cycle sustained while the result register is not stalled; the result of a
// rule is registered through the input register and then the result register after its last byte is taken.
// Reset clears the parse state, so the first byte taken starts a new rule.
// A stalled result register holds the input register, which then drops ready.
`timescale 1ns / 1ps

module match_rule_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    mrp_rule_if.sink      rule_stream,
    mrp_result_if.source  result_stream
);

    logic                  item_valid;
    mrp_pkg::rule_item_t   item;
    logic                  take;
    logic                  out_free;
    logic                  res_load;
    mrp_pkg::result_item_t res_item;

    assign take = item_valid && out_free;

    mrp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .rule_stream (rule_stream),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    mrp_parse_core u_parse_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .consume  (take),
        .item     (item),
        .res_load (res_load),
        .res_item (res_item)
    );

    mrp_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .item          (res_item),
        .free          (out_free),
        .result_stream (result_stream)
    );

endmodule

FILE: src/mrp_checker.sv
// Port-level checks of the match rule parser and their binding.
`timescale 1ns / 1ps

module mrp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rule_valid,
    input logic                  rule_ready,
    input logic                  rule_last,
    input logic                  res_valid,
    input logic                  res_ready,
    input mrp_pkg::result_item_t res_item
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status |->
            res_item.path_offset == '0 && res_item.path_length == '0 &&
            !res_item.path_children &&
            res_item.sender_offset == '0 && res_item.sender_length == '0 &&
            res_item.member_offset == '0 && res_item.member_length == '0 &&
            res_item.interface_offset == '0 && res_item.interface_length == '0)
        else $error("rejected rule carries field data");

    a_children_path: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.path_children |-> res_item.path_offset != '0)
        else $error("namespace flag without a path");

    a_absent_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (res_item.path_offset != '0 || res_item.path_length == '0) &&
            (res_item.sender_offset != '0 || res_item.sender_length == '0) &&
            (res_item.member_offset != '0 || res_item.member_length == '0) &&
            (res_item.interface_offset != '0 || res_item.interface_length == '0))
        else $error("absent field with nonzero length");

    a_res_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rule_valid && rule_ready && rule_last, 2))
        else $error("result without a final byte two cycles before");

endmodule

bind match_rule_parser_unit mrp_checker u_mrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rule_valid (rule_stream.valid),
    .rule_ready (rule_stream.ready),
    .rule_last  (rule_stream.item.last_byte),
    .res_valid  (result_stream.valid),
    .res_ready  (result_stream.ready),
    .res_item   (result_stream.item)
);
